// ----- rtl/cyclic_autocorrelation_scorer_defines.svh -----
`ifndef CYCLIC_AUTOCORRELATION_SCORER_DEFINES_SVH
`define CYCLIC_AUTOCORRELATION_SCORER_DEFINES_SVH

// Same-cycle implication on i_clk, masked while i_rst_n is low.
`define CAS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cas check failed");

// Next-cycle implication on i_clk, masked while i_rst_n is low.
`define CAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cas check failed");

`endif

// ----- rtl/cas_pkg.sv -----
`default_nettype none

package cas_pkg;

    // field widths
    localparam int OP_W        = 2;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int SLK_W       = 8;
    localparam int CAND_LOW_W  = 64;
    localparam int CAND_HIGH_W = 7;
    localparam int MX_W        = 7;
    localparam int WS_W        = 6;
    localparam int TOT_W       = 13;
    localparam int POS_W       = 7;
    localparam int SQ_W        = 19;
    localparam int L1_W        = 12;
    localparam int L2_W        = 18;
    localparam int EN_W        = 31;

    // running sums: 2 * 63 shifts * 127^2 fits in 22 bits
    localparam int ACC_W  = 22;
    // energy MAC: operand, weight and accumulator widths
    localparam int EOP_W  = 19;
    localparam int EK_W   = 24;
    localparam int EACC_W = 33;

    localparam logic signed [SLK_W-1:0] SLK_MAX = 8'sd127;

    // op codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_EVAL  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // energy weights
    localparam logic [EK_W-1:0] W_MX  = 24'd10000000;
    localparam logic [EK_W-1:0] W_TOT = 24'd100000;
    localparam logic [EK_W-1:0] W_POS = 24'd1000;
    localparam logic [EK_W-1:0] W_SQ  = 24'd20;
    localparam logic [EK_W-1:0] W_L1  = 24'd1;

    // energy MAC step order
    localparam int E_STEP_W = 3;
    localparam logic [E_STEP_W-1:0] E_MX  = 3'd0;
    localparam logic [E_STEP_W-1:0] E_TOT = 3'd1;
    localparam logic [E_STEP_W-1:0] E_POS = 3'd2;
    localparam logic [E_STEP_W-1:0] E_SQ  = 3'd3;
    localparam logic [E_STEP_W-1:0] E_L1  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_ESTART,
        S_ENERGY,
        S_DONE
    } t_state;

    // per-shift terms from the correlation unit
    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        d;
        logic [CNT_W-1:0]        ex;
        logic [CNT_W-1:0]        ad;
        logic signed [SLK_W-1:0] slack;
    } t_corr_term;

    // saturated measures fed to the energy unit
    typedef struct packed {
        logic [MX_W-1:0]  mx;
        logic [TOT_W-1:0] tot;
        logic [POS_W-1:0] pos;
        logic [SQ_W-1:0]  sq;
        logic [L1_W-1:0]  l1;
    } t_energy_in;

endpackage

`default_nettype wire

// ----- rtl/cas_table.sv -----
`default_nettype none

module cas_table #(
    parameter int NUM_SHIFTS = 35,
    localparam int AW = (NUM_SHIFTS > 1) ? $clog2(NUM_SHIFTS) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [cas_pkg::CNT_W-1:0] i_wcap,
    input  wire logic [cas_pkg::CNT_W-1:0] i_wtgt,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [cas_pkg::CNT_W-1:0] o_rcap,
    output logic      [cas_pkg::CNT_W-1:0] o_rtgt
);
    import cas_pkg::*;

    // cap in the upper half, target in the lower half
    logic [2*CNT_W-1:0] r_mem [NUM_SHIFTS];
    logic [2*CNT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wcap, i_wtgt};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rcap = r_rdata[2*CNT_W-1:CNT_W];
    assign o_rtgt = r_rdata[CNT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/cas_corr_unit.sv -----
`default_nettype none

module cas_corr_unit #(
    parameter int SEQ_LEN = 71
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_issue,
    input  wire logic [cas_pkg::IDX_W-1:0] i_d,
    input  wire logic [SEQ_LEN-1:0]        i_word,
    input  wire logic [SEQ_LEN-1:0]        i_rot,
    input  wire logic [cas_pkg::CNT_W-1:0] i_cap,
    input  wire logic [cas_pkg::CNT_W-1:0] i_tgt,
    output cas_pkg::t_corr_term            o_term
);
    import cas_pkg::*;

    // stage 1: coincidence count, lines up with the table read data
    logic             r_s1_valid;
    logic [IDX_W-1:0] r_s1_d;
    logic [CNT_W-1:0] r_s1_cnt;

    // stage 2: slack, excess and target distance
    logic signed [SLK_W-1:0] w_slack;
    logic signed [SLK_W-1:0] w_slack_neg;
    logic signed [SLK_W-1:0] w_diff;
    logic signed [SLK_W-1:0] w_diff_neg;
    t_corr_term              r_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_d   <= i_d;
        r_s1_cnt <= CNT_W'($countones(i_word & i_rot));
    end

    always_comb begin
        w_slack     = $signed({1'b0, i_cap}) - $signed({1'b0, r_s1_cnt});
        w_slack_neg = -w_slack;
        w_diff      = $signed({1'b0, r_s1_cnt}) - $signed({1'b0, i_tgt});
        w_diff_neg  = -w_diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term.valid <= 1'b0;
        end else begin
            r_term.valid <= r_s1_valid;
        end
        r_term.d     <= r_s1_d;
        r_term.slack <= w_slack;
        r_term.ex    <= w_slack[SLK_W-1] ? w_slack_neg[CNT_W-1:0] : '0;
        r_term.ad    <= w_diff[SLK_W-1] ? w_diff_neg[CNT_W-1:0] : w_diff[CNT_W-1:0];
    end

    assign o_term = r_term;

endmodule

`default_nettype wire

// ----- rtl/cas_energy_unit.sv -----
`default_nettype none

module cas_energy_unit (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_go,
    input  wire cas_pkg::t_energy_in      i_terms,
    output logic                          o_done,
    output logic [cas_pkg::EN_W-1:0]      o_energy
);
    import cas_pkg::*;

    logic                  r_busy;
    logic [E_STEP_W-1:0]   r_step;
    logic [EACC_W-1:0]     r_acc;
    logic [EOP_W-1:0]      w_op;
    logic [EK_W-1:0]       w_k;
    logic [EOP_W+EK_W-1:0] w_prod;

    // one weighted term per cycle through the shared multiplier
    always_comb begin
        case (r_step)
            E_MX: begin
                w_op = EOP_W'(i_terms.mx);
                w_k  = W_MX;
            end
            E_TOT: begin
                w_op = EOP_W'(i_terms.tot);
                w_k  = W_TOT;
            end
            E_POS: begin
                w_op = EOP_W'(i_terms.pos);
                w_k  = W_POS;
            end
            E_SQ: begin
                w_op = EOP_W'(i_terms.sq);
                w_k  = W_SQ;
            end
            E_L1: begin
                w_op = EOP_W'(i_terms.l1);
                w_k  = W_L1;
            end
            default: begin
                w_op = '0;
                w_k  = '0;
            end
        endcase
        w_prod = (EOP_W+EK_W)'(w_op) * (EOP_W+EK_W)'(w_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + E_STEP_W'(1);
            if (r_step == E_L1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_prod[EACC_W-1:0];
        end
    end

    assign o_done   = r_busy && (r_step == E_L1);
    assign o_energy = (r_acc[EACC_W-1:EN_W] != '0) ? {EN_W{1'b1}} : r_acc[EN_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/cyclic_autocorrelation_scorer.sv -----
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  command  | in        | start & !busy      | i_op, i_shift_index, i_cap_value,
//           |           |                    | i_target_value, i_cand_low, i_cand_high
//  result   | out       | o_valid (1 cycle)  | o_peak_over .. o_better_than_best
//
//  Load (op 0), clear best (op 2) and unused op 3 finish at the accepting edge; busy stays low.
//  Evaluate (op 1): busy through the scan, drain, energy and compare steps; the result beat is
//  on the ports in the first cycle with busy low again. The steps run as one shift per cycle
//  through the popcount unit and the table read port, two term stages draining, the energy
//  start state, five steps of the shared energy multiplier and one compare step.
//  Reset is synchronous, active low; the cap/target table is not cleared.
//  The receiver cannot stall: each result beat is taken in its one strobe cycle.
`default_nettype none

`include "cyclic_autocorrelation_scorer_defines.svh"

module cyclic_autocorrelation_scorer #(
    parameter int SEQ_LEN    = 71,
    parameter int NUM_SHIFTS = 35
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [cas_pkg::OP_W-1:0]        i_op,
    input  wire logic [cas_pkg::IDX_W-1:0]       i_shift_index,
    input  wire logic [cas_pkg::CNT_W-1:0]       i_cap_value,
    input  wire logic [cas_pkg::CNT_W-1:0]       i_target_value,
    input  wire logic [cas_pkg::CAND_LOW_W-1:0]  i_cand_low,
    input  wire logic [cas_pkg::CAND_HIGH_W-1:0] i_cand_high,
    output logic                                 o_valid,
    output logic [cas_pkg::MX_W-1:0]             o_peak_over,
    output logic [cas_pkg::WS_W-1:0]             o_worst_shift,
    output logic [cas_pkg::TOT_W-1:0]            o_over_sum,
    output logic [cas_pkg::POS_W-1:0]            o_over_hits,
    output logic [cas_pkg::SQ_W-1:0]             o_over_sq_sum,
    output logic [cas_pkg::L1_W-1:0]             o_tgt_dist_abs,
    output logic [cas_pkg::L2_W-1:0]             o_tgt_dist_sq,
    output logic signed [cas_pkg::SLK_W-1:0]     o_slack_floor,
    output logic [cas_pkg::EN_W-1:0]             o_energy,
    output logic                                 o_better_than_best
);
    import cas_pkg::*;

    localparam int AW     = (NUM_SHIFTS > 1) ? $clog2(NUM_SHIFTS) : 1;
    localparam int FULL_W = 128;

    // sequencer
    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_eval;
    logic   w_issue;
    logic   w_e_go;
    logic   w_finish;

    // candidate and its rotation; r_rot is the word rotated by the shift in r_d
    logic [FULL_W-1:0]  w_full;
    logic [SEQ_LEN-1:0] w_word;
    logic [SEQ_LEN-1:0] r_word;
    logic [SEQ_LEN-1:0] r_rot;
    logic [IDX_W-1:0]   r_d;
    logic [IDX_W-1:0]   w_d_m1;
    logic [IDX_W-1:0]   w_idx_m1;
    logic               w_we;

    // table read
    logic [CNT_W-1:0] w_rcap;
    logic [CNT_W-1:0] w_rtgt;

    // per-shift terms
    t_corr_term          w_term;
    logic [2*CNT_W-1:0]  w_ex_sq;
    logic [2*CNT_W-1:0]  w_ad_sq;

    // running sums
    logic [MX_W-1:0]         r_mx;
    logic [WS_W-1:0]         r_worst;
    logic [ACC_W-1:0]        r_tot;
    logic [ACC_W-1:0]        r_pos;
    logic [ACC_W-1:0]        r_sq;
    logic [ACC_W-1:0]        r_l1;
    logic [ACC_W-1:0]        r_l2;
    logic signed [SLK_W-1:0] r_min;

    // saturated measures
    logic [TOT_W-1:0] w_tot_sat;
    logic [POS_W-1:0] w_pos_sat;
    logic [SQ_W-1:0]  w_sq_sat;
    logic [L1_W-1:0]  w_l1_sat;
    logic [L2_W-1:0]  w_l2_sat;
    t_energy_in       w_e_terms;
    logic             w_e_done;
    logic [EN_W-1:0]  w_energy;

    // kept best
    logic                    r_best_valid;
    logic [MX_W-1:0]         r_best_mx;
    logic [TOT_W-1:0]        r_best_tot;
    logic [POS_W-1:0]        r_best_pos;
    logic [SQ_W-1:0]         r_best_sq;
    logic [L1_W-1:0]         r_best_l1;
    logic [L2_W-1:0]         r_best_l2;
    logic signed [SLK_W-1:0] r_best_slack;
    logic                    w_less;
    logic                    w_better;

    // result registers
    logic                    r_valid;
    logic [MX_W-1:0]         r_o_mx;
    logic [WS_W-1:0]         r_o_worst;
    logic [TOT_W-1:0]        r_o_tot;
    logic [POS_W-1:0]        r_o_pos;
    logic [SQ_W-1:0]         r_o_sq;
    logic [L1_W-1:0]         r_o_l1;
    logic [L2_W-1:0]         r_o_l2;
    logic signed [SLK_W-1:0] r_o_slack;
    logic [EN_W-1:0]         r_o_energy;
    logic                    r_o_better;

    // ---------------------------------------------------------------- command decode
    assign w_accept = start && !busy;
    assign w_eval   = w_accept && (i_op == OP_EVAL);
    assign w_idx_m1 = i_shift_index - IDX_W'(1);
    // loads to shift 0 or beyond the table are dropped
    assign w_we     = w_accept && (i_op == OP_LOAD) && (i_shift_index != '0)
                      && (i_shift_index <= IDX_W'(NUM_SHIFTS));

    // bits above SEQ_LEN are dropped; a longer word gets zeros on top
    assign w_full = FULL_W'({i_cand_high, i_cand_low});
    assign w_word = w_full[SEQ_LEN-1:0];

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_eval) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_d == IDX_W'(NUM_SHIFTS)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last shift's terms land in the sums at this edge
                if (w_term.valid && (w_term.d == IDX_W'(NUM_SHIFTS))) begin
                    n_state = S_ESTART;
                end
            end
            S_ESTART: begin
                n_state = S_ENERGY;
            end
            S_ENERGY: begin
                if (w_e_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy     = 1'b1;
        w_issue  = 1'b0;
        w_e_go   = 1'b0;
        w_finish = 1'b0;
        case (r_state)
            S_IDLE:   busy     = 1'b0;
            S_SCAN:   w_issue  = 1'b1;
            S_DRAIN:  busy     = 1'b1;
            S_ESTART: w_e_go   = 1'b1;
            S_ENERGY: busy     = 1'b1;
            S_DONE:   w_finish = 1'b1;
            default:  busy     = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // shift counter and rotating copy, one shift per cycle
    always_ff @(posedge i_clk) begin
        if (w_eval) begin
            r_word <= w_word;
            r_rot  <= {w_word[0], w_word[SEQ_LEN-1:1]};
            r_d    <= IDX_W'(1);
        end else if (w_issue && (r_d != IDX_W'(NUM_SHIFTS))) begin
            r_rot  <= {r_rot[0], r_rot[SEQ_LEN-1:1]};
            r_d    <= r_d + IDX_W'(1);
        end
    end

    assign w_d_m1 = r_d - IDX_W'(1);

    // ---------------------------------------------------------------- datapath
    cas_table #(
        .NUM_SHIFTS (NUM_SHIFTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx_m1[AW-1:0]),
        .i_wcap  (i_cap_value),
        .i_wtgt  (i_target_value),
        .i_raddr (w_d_m1[AW-1:0]),
        .o_rcap  (w_rcap),
        .o_rtgt  (w_rtgt)
    );

    cas_corr_unit #(
        .SEQ_LEN (SEQ_LEN)
    ) u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (w_issue),
        .i_d     (r_d),
        .i_word  (r_word),
        .i_rot   (r_rot),
        .i_cap   (w_rcap),
        .i_tgt   (w_rtgt),
        .o_term  (w_term)
    );

    assign w_ex_sq = (2*CNT_W)'(w_term.ex) * (2*CNT_W)'(w_term.ex);
    assign w_ad_sq = (2*CNT_W)'(w_term.ad) * (2*CNT_W)'(w_term.ad);

    // accumulate one shift's terms per cycle; excess sums are kept doubled
    always_ff @(posedge i_clk) begin
        if (w_eval) begin
            r_mx    <= '0;
            r_worst <= '0;
            r_tot   <= '0;
            r_pos   <= '0;
            r_sq    <= '0;
            r_l1    <= '0;
            r_l2    <= '0;
            r_min   <= SLK_MAX;
        end else if (w_term.valid) begin
            // strict compare keeps the first shift reaching the max
            if (w_term.ex > r_mx) begin
                r_mx    <= w_term.ex;
                r_worst <= w_term.d;
            end
            r_tot <= r_tot + ACC_W'({w_term.ex, 1'b0});
            r_pos <= r_pos + ((w_term.ex != '0) ? ACC_W'(2) : ACC_W'(0));
            r_sq  <= r_sq + ACC_W'({w_ex_sq, 1'b0});
            r_l1  <= r_l1 + ACC_W'(w_term.ad);
            r_l2  <= r_l2 + ACC_W'(w_ad_sq);
            if (w_term.slack < r_min) begin
                r_min <= w_term.slack;
            end
        end
    end

    // clamp to the field widths
    always_comb begin
        w_tot_sat = (r_tot[ACC_W-1:TOT_W] != '0) ? {TOT_W{1'b1}} : r_tot[TOT_W-1:0];
        w_pos_sat = (r_pos[ACC_W-1:POS_W] != '0) ? {POS_W{1'b1}} : r_pos[POS_W-1:0];
        w_sq_sat  = (r_sq[ACC_W-1:SQ_W]   != '0) ? {SQ_W{1'b1}}  : r_sq[SQ_W-1:0];
        w_l1_sat  = (r_l1[ACC_W-1:L1_W]   != '0) ? {L1_W{1'b1}}  : r_l1[L1_W-1:0];
        w_l2_sat  = (r_l2[ACC_W-1:L2_W]   != '0) ? {L2_W{1'b1}}  : r_l2[L2_W-1:0];
    end

    always_comb begin
        w_e_terms.mx  = r_mx;
        w_e_terms.tot = w_tot_sat;
        w_e_terms.pos = w_pos_sat;
        w_e_terms.sq  = w_sq_sat;
        w_e_terms.l1  = w_l1_sat;
    end

    cas_energy_unit u_energy (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_e_go),
        .i_terms  (w_e_terms),
        .o_done   (w_e_done),
        .o_energy (w_energy)
    );

    // ---------------------------------------------------------------- best compare
    // smaller wins field by field; slack last, where larger wins
    always_comb begin
        if (r_mx != r_best_mx) begin
            w_less = r_mx < r_best_mx;
        end else if (w_tot_sat != r_best_tot) begin
            w_less = w_tot_sat < r_best_tot;
        end else if (w_pos_sat != r_best_pos) begin
            w_less = w_pos_sat < r_best_pos;
        end else if (w_sq_sat != r_best_sq) begin
            w_less = w_sq_sat < r_best_sq;
        end else if (w_l1_sat != r_best_l1) begin
            w_less = w_l1_sat < r_best_l1;
        end else if (w_l2_sat != r_best_l2) begin
            w_less = w_l2_sat < r_best_l2;
        end else begin
            w_less = r_min > r_best_slack;
        end
        w_better = !r_best_valid || w_less;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
            r_best_mx    <= '0;
            r_best_tot   <= '0;
            r_best_pos   <= '0;
            r_best_sq    <= '0;
            r_best_l1    <= '0;
            r_best_l2    <= '0;
            r_best_slack <= '0;
        end else if (w_accept && (i_op == OP_CLEAR)) begin
            r_best_valid <= 1'b0;
            r_best_mx    <= '0;
            r_best_tot   <= '0;
            r_best_pos   <= '0;
            r_best_sq    <= '0;
            r_best_l1    <= '0;
            r_best_l2    <= '0;
            r_best_slack <= '0;
        end else if (w_finish && w_better) begin
            r_best_valid <= 1'b1;
            r_best_mx    <= r_mx;
            r_best_tot   <= w_tot_sat;
            r_best_pos   <= w_pos_sat;
            r_best_sq    <= w_sq_sat;
            r_best_l1    <= w_l1_sat;
            r_best_l2    <= w_l2_sat;
            r_best_slack <= r_min;
        end
    end

    // ---------------------------------------------------------------- result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_o_mx     <= r_mx;
            r_o_worst  <= r_worst;
            r_o_tot    <= w_tot_sat;
            r_o_pos    <= w_pos_sat;
            r_o_sq     <= w_sq_sat;
            r_o_l1     <= w_l1_sat;
            r_o_l2     <= w_l2_sat;
            r_o_slack  <= r_min;
            r_o_energy <= w_energy;
            r_o_better <= w_better;
        end
    end

    assign o_valid            = r_valid;
    assign o_peak_over        = r_o_mx;
    assign o_worst_shift      = r_o_worst;
    assign o_over_sum         = r_o_tot;
    assign o_over_hits        = r_o_pos;
    assign o_over_sq_sum      = r_o_sq;
    assign o_tgt_dist_abs     = r_o_l1;
    assign o_tgt_dist_sq      = r_o_l2;
    assign o_slack_floor      = r_o_slack;
    assign o_energy           = r_o_energy;
    assign o_better_than_best = r_o_better;

    // ---------------------------------------------------------------- checks
    `CAS_ASSERT_NEXT(a_eval_starts_scan, w_eval, r_state == S_SCAN)
    `CAS_ASSERT_SAME(a_scan_in_range, r_state == S_SCAN, (r_d != '0) && (r_d <= IDX_W'(NUM_SHIFTS)))
    `CAS_ASSERT_SAME(a_term_window, w_term.valid, (r_state == S_SCAN) || (r_state == S_DRAIN))
    `CAS_ASSERT_NEXT(a_done_beat, r_state == S_DONE, o_valid && (r_state == S_IDLE))
    `CAS_ASSERT_SAME(a_better_kept, o_valid && o_better_than_best, r_best_valid)

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import cas_pkg::*;

    localparam int SEQ_BITS    = 71;
    localparam int NSHIFT      = 35;
    // the eval busy window plus the result beat, with margin
    localparam int DRAIN_TAIL  = 2 * (NSHIFT + 10);
    // cycles without any beat in either direction before the run is called dead
    localparam int STALL_LIMIT = 4000;

    // op 3 has no name in the package; the block ignores it
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef enum int {FILL_ZERO, FILL_MAX, FILL_TYPICAL, FILL_WIDE} t_fill_mode;

    // one command beat, plus the idle cycles the driver inserts ahead of it
    typedef struct {
        logic [OP_W-1:0]        op;
        logic [IDX_W-1:0]       idx;
        logic [CNT_W-1:0]       cap;
        logic [CNT_W-1:0]       tgt;
        logic [CAND_LOW_W-1:0]  lo;
        logic [CAND_HIGH_W-1:0] hi;
        int                     gap;
        bit                     drain;  // hold off until all scores are back
    } t_cmd;

    typedef struct {
        logic [MX_W-1:0]         mx;
        logic [WS_W-1:0]         ws;
        logic [TOT_W-1:0]        tot;
        logic [POS_W-1:0]        pos;
        logic [SQ_W-1:0]         sq;
        logic [L1_W-1:0]         l1;
        logic [L2_W-1:0]         l2;
        logic signed [SLK_W-1:0] slack;
        logic [EN_W-1:0]         energy;
        logic                    better;
    } t_score;

    // ---------------------------------------------------------------- DUT
    logic                   i_clk;
    logic                   i_rst_n        = 1'b0;
    logic                   start          = 1'b0;
    logic [OP_W-1:0]        i_op           = '0;
    logic [IDX_W-1:0]       i_shift_index  = '0;
    logic [CNT_W-1:0]       i_cap_value    = '0;
    logic [CNT_W-1:0]       i_target_value = '0;
    logic [CAND_LOW_W-1:0]  i_cand_low     = '0;
    logic [CAND_HIGH_W-1:0] i_cand_high    = '0;

    logic                    busy;
    logic                    o_valid;
    logic [MX_W-1:0]         o_peak_over;
    logic [WS_W-1:0]         o_worst_shift;
    logic [TOT_W-1:0]        o_over_sum;
    logic [POS_W-1:0]        o_over_hits;
    logic [SQ_W-1:0]         o_over_sq_sum;
    logic [L1_W-1:0]         o_tgt_dist_abs;
    logic [L2_W-1:0]         o_tgt_dist_sq;
    logic signed [SLK_W-1:0] o_slack_floor;
    logic [EN_W-1:0]         o_energy;
    logic                    o_better_than_best;

    cyclic_autocorrelation_scorer #(
        .SEQ_LEN    (SEQ_BITS),
        .NUM_SHIFTS (NSHIFT)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_op               (i_op),
        .i_shift_index      (i_shift_index),
        .i_cap_value        (i_cap_value),
        .i_target_value     (i_target_value),
        .i_cand_low         (i_cand_low),
        .i_cand_high        (i_cand_high),
        .o_valid            (o_valid),
        .o_peak_over        (o_peak_over),
        .o_worst_shift      (o_worst_shift),
        .o_over_sum         (o_over_sum),
        .o_over_hits        (o_over_hits),
        .o_over_sq_sum      (o_over_sq_sum),
        .o_tgt_dist_abs     (o_tgt_dist_abs),
        .o_tgt_dist_sq      (o_tgt_dist_sq),
        .o_slack_floor      (o_slack_floor),
        .o_energy           (o_energy),
        .o_better_than_best (o_better_than_best)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- scoreboard state
    t_cmd   cmd_q[$];     // commands not yet on the bus
    t_score score_q[$];   // predicted scores, oldest first

    // predictor's copy of the block state
    logic [CNT_W-1:0] cap_tab [1:NSHIFT];
    logic [CNT_W-1:0] tgt_tab [1:NSHIFT];
    logic             best_kept = 1'b0;
    t_score           best_score;

    // driver-side bookkeeping (blocking, driver process only)
    t_cmd cur_cmd;
    bit   have_cur  = 1'b0;
    bit   shown     = 1'b0;
    int   gap_left  = 0;
    int   evals_sent = 0;

    int results_seen = 0;   // bumped by the monitor with NB so the driver sees a stable count
    int idle_cycles  = 0;
    int errors       = 0;
    bit calm         = 1'b0;  // no idle gaps while set

    int n_eval = 0, n_better = 0, n_excess = 0, n_load = 0, n_bad_load = 0;
    int n_clear = 0, n_spare = 0, n_checked = 0;

    function automatic longint clip(input longint v, input int bits);
        longint top;
        top = (longint'(1) << bits) - 1;
        return (v > top) ? top : v;
    endfunction

    // Periodic autocorrelation against the cap/target tables. Rotation by d
    // puts bit (i+d) mod 71 at position i, so the AND counts coincidences.
    function automatic t_score score_candidate(input logic [CAND_LOW_W-1:0] lo,
                                               input logic [CAND_HIGH_W-1:0] hi);
        t_score              s;
        logic [SEQ_BITS-1:0] w, rot;
        int                  hits, slk, ex, ad, top_ex, top_d;
        int                  tot, pos, sq, l1, l2, low_slk;
        longint              en;
        w = {hi, lo};
        top_ex = 0;
        top_d = 0;
        tot = 0;
        pos = 0;
        sq = 0;
        l1 = 0;
        l2 = 0;
        low_slk = 1 << 20;
        for (int d = 1; d <= NSHIFT; d++) begin
            rot  = (w >> d) | (w << (SEQ_BITS - d));
            hits = $countones(w & rot);
            slk  = int'(cap_tab[d]) - hits;
            ad   = hits - int'(tgt_tab[d]);
            if (ad < 0) ad = -ad;
            ex   = (slk < 0) ? -slk : 0;
            // strict compare keeps the first shift on a tie
            if (ex > top_ex) begin
                top_ex = ex;
                top_d  = d;
            end
            tot += 2 * ex;
            pos += (ex > 0) ? 2 : 0;
            sq  += 2 * ex * ex;
            l1  += ad;
            l2  += ad * ad;
            if (slk < low_slk) low_slk = slk;
        end
        // every field saturates at its port width; energy uses the clipped values
        s.mx  = MX_W'(clip(top_ex, MX_W));
        s.ws  = WS_W'(clip(top_d, WS_W));
        s.tot = TOT_W'(clip(tot, TOT_W));
        s.pos = POS_W'(clip(pos, POS_W));
        s.sq  = SQ_W'(clip(sq, SQ_W));
        s.l1  = L1_W'(clip(l1, L1_W));
        s.l2  = L2_W'(clip(l2, L2_W));
        if (low_slk > 127) low_slk = 127;
        if (low_slk < -128) low_slk = -128;
        s.slack = SLK_W'(low_slk);
        en = longint'(s.mx) * 10000000 + longint'(s.tot) * 100000
           + longint'(s.pos) * 1000 + longint'(s.sq) * 20 + longint'(s.l1);
        s.energy = EN_W'(clip(en, EN_W));
        s.better = 1'b0;
        return s;
    endfunction

    // Advance the predictor by one accepted command beat.
    task automatic apply_command(input t_cmd c);
        t_score s;
        logic   win;
        case (c.op)
            OP_LOAD: begin
                // out-of-range shift index is dropped
                if (c.idx >= 1 && c.idx <= NSHIFT) begin
                    cap_tab[c.idx] = c.cap;
                    tgt_tab[c.idx] = c.tgt;
                    n_load++;
                end else begin
                    n_bad_load++;
                end
            end
            OP_EVAL: begin
                s = score_candidate(c.lo, c.hi);
                // lexicographic: smaller wins field by field, larger slack last
                if (!best_kept)                    win = 1'b1;
                else if (s.mx  != best_score.mx)   win = s.mx  < best_score.mx;
                else if (s.tot != best_score.tot)  win = s.tot < best_score.tot;
                else if (s.pos != best_score.pos)  win = s.pos < best_score.pos;
                else if (s.sq  != best_score.sq)   win = s.sq  < best_score.sq;
                else if (s.l1  != best_score.l1)   win = s.l1  < best_score.l1;
                else if (s.l2  != best_score.l2)   win = s.l2  < best_score.l2;
                else                               win = s.slack > best_score.slack;
                s.better = win;
                if (win) begin
                    best_score = s;
                    best_kept  = 1'b1;
                    n_better++;
                end
                if (s.mx != 0) n_excess++;
                score_q.push_back(s);
                evals_sent++;
                n_eval++;
            end
            OP_CLEAR: begin
                // tables survive a clear; only the kept best goes
                best_kept  = 1'b0;
                best_score = '{default: '0};
                n_clear++;
            end
            default: begin
                n_spare++;
            end
        endcase
    endtask

    // ---------------------------------------------------------------- stimulus helpers
    task automatic push_cmd(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic [CNT_W-1:0] cap, input logic [CNT_W-1:0] tgt,
                            input logic [CAND_LOW_W-1:0] lo,
                            input logic [CAND_HIGH_W-1:0] hi, input bit drain);
        t_cmd c;
        int   r;
        c.op    = op;
        c.idx   = idx;
        c.cap   = cap;
        c.tgt   = tgt;
        c.lo    = lo;
        c.hi    = hi;
        c.drain = drain;
        // mostly back to back, some short gaps, a few long enough to outlast busy
        r = $urandom_range(0, 99);
        if (calm)        c.gap = 0;
        else if (r < 55) c.gap = 0;
        else if (r < 88) c.gap = $urandom_range(1, 4);
        else if (r < 97) c.gap = $urandom_range(5, 20);
        else             c.gap = $urandom_range(40, 80);
        cmd_q.push_back(c);
    endtask

    task automatic push_eval(input logic [SEQ_BITS-1:0] w, input bit drain);
        push_cmd(OP_EVAL, IDX_W'($urandom_range(0, 63)), CNT_W'($urandom_range(0, 127)),
                 CNT_W'($urandom_range(0, 127)), w[63:0], w[SEQ_BITS-1:64], drain);
    endtask

    // Candidate mix: uniform, sparse, dense (inverted sparse), all-zero/all-one.
    task automatic push_random_eval(input bit drain);
        logic [SEQ_BITS-1:0] w;
        int                  style;
        style = $urandom_range(0, 9);
        if (style < 5) begin
            w = SEQ_BITS'({$urandom, $urandom, $urandom});
        end else if (style < 9) begin
            w = '0;
            repeat ($urandom_range(1, 10)) w[$urandom_range(0, SEQ_BITS - 1)] = 1'b1;
            if (style >= 7) w = ~w;
        end else begin
            w = $urandom_range(0, 1) ? '0 : '1;
        end
        push_eval(w, drain);
    endtask

    // Rewrite every table entry; unused candidate fields carry noise.
    task automatic fill_tables(input t_fill_mode mode);
        logic [CNT_W-1:0] cap, tgt;
        for (int k = 1; k <= NSHIFT; k++) begin
            case (mode)
                FILL_ZERO: begin
                    cap = '0;
                    tgt = '0;
                end
                FILL_MAX: begin
                    cap = '1;
                    tgt = '1;
                end
                FILL_TYPICAL: begin
                    cap = CNT_W'($urandom_range(12, 24));
                    tgt = CNT_W'($urandom_range(10, 24));
                end
                default: begin
                    cap = CNT_W'($urandom_range(0, 127));
                    tgt = CNT_W'($urandom_range(0, 127));
                end
            endcase
            push_cmd(OP_LOAD, IDX_W'(k), cap, tgt, {$urandom, $urandom},
                     CAND_HIGH_W'($urandom_range(0, 127)), 1'b0);
        end
    endtask

    // ---------------------------------------------------------------- driver
    // Command beat lands on an edge with start high and busy low. start is
    // assigned once per edge, so a held start never dips between beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_command(cur_cmd);
                have_cur = 1'b0;
                shown    = 1'b0;
            end
            if (!have_cur && cmd_q.size() != 0) begin
                cur_cmd  = cmd_q.pop_front();
                have_cur = 1'b1;
                shown    = 1'b0;
                gap_left = cur_cmd.gap;
            end
            if (have_cur && !shown) begin
                if (gap_left > 0)
                    gap_left--;
                else if (!cur_cmd.drain || evals_sent == results_seen)
                    shown = 1'b1;
            end
            start <= have_cur && shown;
            if (have_cur && shown) begin
                i_op           <= cur_cmd.op;
                i_shift_index  <= cur_cmd.idx;
                i_cap_value    <= cur_cmd.cap;
                i_target_value <= cur_cmd.tgt;
                i_cand_low     <= cur_cmd.lo;
                i_cand_high    <= cur_cmd.hi;
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Result beats cannot be held off: each is taken in its single strobe cycle.
    always @(posedge i_clk) begin : watch_results
        t_score want;
        if (i_rst_n && o_valid) begin
            results_seen <= results_seen + 1;
            if (score_q.size() == 0) begin
                $error("result beat with no score expected");
                errors++;
            end else begin
                want = score_q.pop_front();
                check_field("peak_over", 64'(want.mx), 64'(o_peak_over));
                check_field("worst_shift", 64'(want.ws), 64'(o_worst_shift));
                check_field("over_sum", 64'(want.tot), 64'(o_over_sum));
                check_field("over_hits", 64'(want.pos), 64'(o_over_hits));
                check_field("over_sq_sum", 64'(want.sq), 64'(o_over_sq_sum));
                check_field("tgt_dist_abs", 64'(want.l1), 64'(o_tgt_dist_abs));
                check_field("tgt_dist_sq", 64'(want.l2), 64'(o_tgt_dist_sq));
                check_field("slack_floor", 64'(want.slack), 64'(o_slack_floor));
                check_field("energy", 64'(want.energy), 64'(o_energy));
                check_field("better_than_best", 64'(want.better), 64'(o_better_than_best));
                n_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (i_rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("tb_top failed");
        $finish;
    end

    // ---------------------------------------------------------------- test sequence
    initial begin
        int r;
        logic [SEQ_BITS-1:0] w;

        // Directed. All-zero tables first: every coincidence is excess.
        push_cmd(OP_SPARE, '1, '1, '1, '1, '1, 1'b0);
        fill_tables(FILL_ZERO);
        // out-of-range loads with extreme values must leave the tables alone
        push_cmd(OP_LOAD, 6'd0, '1, '1, '0, '0, 1'b0);
        push_cmd(OP_LOAD, IDX_W'(NSHIFT + 1), '1, '1, '0, '0, 1'b0);
        push_cmd(OP_LOAD, 6'd63, '1, '1, '0, '0, 1'b0);
        push_eval('0, 1'b0);                        // nothing kept: better
        push_eval('0, 1'b0);                        // tie: not better
        push_eval('1, 1'b0);                        // every shift at full excess
        w = '0;
        w[SEQ_BITS-1] = 1'b1;
        push_eval(w, 1'b0);                         // one bit: no coincidences
        push_eval({7'h00, {64{1'b1}}}, 1'b0);
        push_eval({7'h7F, 64'h0}, 1'b0);
        push_cmd(OP_CLEAR, '0, '0, '0, '0, '0, 1'b1);  // wait for all scores first
        push_eval('1, 1'b0);                        // after clear: better again
        push_eval({3'b101, {17{4'b1100}}}, 1'b0);
        // saturating tables: target L1/L2 overflow, slack at the top
        fill_tables(FILL_MAX);
        push_eval('0, 1'b0);
        push_eval('1, 1'b0);
        push_cmd(OP_SPARE, 6'd5, 7'd3, 7'd3, '0, '0, 1'b0);
        fill_tables(FILL_TYPICAL);
        push_random_eval(1'b1);

        // Random part: mostly evaluations against moving tables.
        for (int i = 0; i < 950; i++) begin
            calm = ((i / 120) % 4) == 1;
            r = $urandom_range(0, 999);
            if (r < 730) begin
                push_random_eval($urandom_range(0, 49) == 0);
            end else if (r < 850) begin
                if ($urandom_range(0, 4) == 0)
                    push_cmd(OP_LOAD, IDX_W'($urandom_range(1, NSHIFT)),
                             CNT_W'($urandom_range(0, 127)), CNT_W'($urandom_range(0, 127)),
                             {$urandom, $urandom}, CAND_HIGH_W'($urandom_range(0, 127)),
                             1'b0);
                else
                    push_cmd(OP_LOAD, IDX_W'($urandom_range(1, NSHIFT)),
                             CNT_W'($urandom_range(12, 24)), CNT_W'($urandom_range(10, 24)),
                             {$urandom, $urandom}, CAND_HIGH_W'($urandom_range(0, 127)),
                             1'b0);
            end else if (r < 880) begin
                push_cmd(OP_LOAD,
                         IDX_W'($urandom_range(0, 1) ? 0 : $urandom_range(NSHIFT + 1, 63)),
                         CNT_W'($urandom_range(0, 127)), CNT_W'($urandom_range(0, 127)),
                         {$urandom, $urandom}, CAND_HIGH_W'($urandom_range(0, 127)), 1'b0);
            end else if (r < 940) begin
                push_cmd(OP_CLEAR, IDX_W'($urandom_range(0, 63)),
                         CNT_W'($urandom_range(0, 127)), CNT_W'($urandom_range(0, 127)),
                         {$urandom, $urandom}, CAND_HIGH_W'($urandom_range(0, 127)),
                         $urandom_range(0, 3) == 0);
            end else if (r < 970) begin
                push_cmd(OP_SPARE, IDX_W'($urandom_range(0, 63)),
                         CNT_W'($urandom_range(0, 127)), CNT_W'($urandom_range(0, 127)),
                         {$urandom, $urandom}, CAND_HIGH_W'($urandom_range(0, 127)), 1'b0);
            end else if (r < 980) begin
                r = $urandom_range(0, 9);
                fill_tables(r < 6 ? FILL_TYPICAL : r < 8 ? FILL_WIDE : r < 9 ? FILL_ZERO
                                                                      : FILL_MAX);
            end else begin
                push_eval('1, 1'b0);
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample on the falling edge so the driver's bookkeeping has settled
        while (cmd_q.size() != 0 || have_cur || evals_sent != results_seen)
            @(negedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (score_q.size() != 0) begin
            $error("%0d scores never arrived", score_q.size());
            errors++;
        end

        $display("covered %0d evaluations (%0d new best, %0d over cap), %0d clears",
                 n_eval, n_better, n_excess, n_clear);
        $display("%0d table writes, %0d out-of-range loads, %0d op-3 beats, %0d scores checked",
                 n_load, n_bad_load, n_spare, n_checked);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/cas_pkg.sv
rtl/cas_table.sv
rtl/cas_corr_unit.sv
rtl/cas_energy_unit.sv
rtl/cyclic_autocorrelation_scorer.sv
tb/sv/tb_top.sv
